// File: design/bilinear_image_scaler_top_defines.svh
// Assertion macros for the bilinear image scaler.
// Used by the top level only; needs a clock named clk and reset arst_n in scope.
`ifndef BILINEAR_IMAGE_SCALER_TOP_DEFINES_SVH
`define BILINEAR_IMAGE_SCALER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BIS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bilinear scaler check failed");

// Next-cycle implication, disabled during reset.
`define BIS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bilinear scaler check failed");

`endif

// File: design/bis_pkg.sv
// Shared types and constants of the bilinear image scaler.
// No dependencies; used by the front end, queue, back end and top level.
package bis_pkg;

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_IN_WIDTH   = 3'd0;
	localparam logic [2:0] REG_IN_HEIGHT  = 3'd1;
	localparam logic [2:0] REG_OUT_WIDTH  = 3'd2;
	localparam logic [2:0] REG_OUT_HEIGHT = 3'd3;
	localparam logic [2:0] REG_STEP       = 3'd4;

	// Clamp limits of the frame sizes and of the results per job.
	localparam logic [12:0] MAX_IN_HEIGHT  = 13'd4096;
	localparam logic [12:0] MAX_OUT_WIDTH  = 13'd4096;
	localparam logic [14:0] MAX_OUT_HEIGHT = 15'd16384;
	localparam logic [5:0]  MAX_RESULTS_M1 = 6'd63;

	// One unit of work for the back end: the block of output pixels one
	// input word completes, plus the four neighbor pixels.
	typedef struct packed {
		logic [23:0] cur;
		logic [23:0] above;
		logic [23:0] left;
		logic [23:0] left_above;
		logic [12:0] col;
		logic [12:0] row;
		logic [12:0] x0;
		logic [12:0] x1;
		logic [23:0] px0;
		logic [14:0] y0;
		logic [14:0] y1;
		logic [25:0] py0;
	} job_t;

	// Queue status seen by the producer and the consumer.
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

// File: design/bis_ram.sv
// Generic simple dual-port RAM with a registered read.
// No dependencies.
module bis_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: design/bis_front.sv
// Front end: configuration, input intake, line store and output range scan.
// Depends on bis_pkg and bis_ram.
module bis_front #(
	parameter int MAX_LINE_WIDTH = 1024,
	parameter int FRAC_BITS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [2:0]             cfg_index,
	input  logic [14:0]            cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [23:0]            in_pixel,
	output logic [10:0]            step,
	output logic                   push,
	output bis_pkg::job_t          job,
	input  bis_pkg::queue_status_t qstat
);

	localparam int CW = $clog2(MAX_LINE_WIDTH);
	localparam logic [12:0] MAXW = 13'(MAX_LINE_WIDTH);

	typedef enum logic [2:0] {S_IDLE, S_READ, S_SCANX, S_SCANY, S_PUSH} state_t;
	state_t state_q;

	logic [10:0] in_width_q;
	logic [12:0] in_height_q;
	logic [12:0] out_width_q;
	logic [14:0] out_height_q;
	logic [10:0] step_q;

	logic [CW-1:0] in_col_q;
	logic [11:0]   in_row_q;
	logic [14:0]   nor_q;
	logic [25:0]   npy_q;
	logic [12:0]   roc_q;
	logic [23:0]   rpx_q;
	logic [23:0]   left_q, la_q, cur_q, above_q;
	logic [12:0]   c_q, r_q;
	logic [12:0]   x0_q, cx_q;
	logic [23:0]   px0_q, cpx_q;
	logic [14:0]   cy_q;
	logic [25:0]   cpy_q;

	logic [12:0] w_eff, h_eff, ow_eff, wm1, hm1, c_new, r_new;
	logic [14:0] oh_eff;
	logic [24:0] dx;
	logic [26:0] dy;
	logic        hit_x, hit_y, nonempty, accept;
	logic [23:0] rdata;

	// Effective frame sizes after clamping.
	always_comb begin
		if (in_width_q == 11'd0) begin
			w_eff = 13'd1;
		end else if ({2'b00, in_width_q} > MAXW) begin
			w_eff = MAXW;
		end else begin
			w_eff = {2'b00, in_width_q};
		end
		if (in_height_q == 13'd0) begin
			h_eff = 13'd1;
		end else if (in_height_q > bis_pkg::MAX_IN_HEIGHT) begin
			h_eff = bis_pkg::MAX_IN_HEIGHT;
		end else begin
			h_eff = in_height_q;
		end
		ow_eff = (out_width_q > bis_pkg::MAX_OUT_WIDTH) ? bis_pkg::MAX_OUT_WIDTH : out_width_q;
		oh_eff = (out_height_q > bis_pkg::MAX_OUT_HEIGHT) ?
			bis_pkg::MAX_OUT_HEIGHT : out_height_q;
		wm1 = w_eff - 13'd1;
		hm1 = h_eff - 13'd1;
		c_new = ({{(13-CW){1'b0}}, in_col_q} >= w_eff) ? wm1 : {{(13-CW){1'b0}}, in_col_q};
		r_new = ({1'b0, in_row_q} >= h_eff) ? hm1 : {1'b0, in_row_q};
	end

	// Completion test of the current output column and row.
	always_comb begin
		dx = 25'(cpx_q >> FRAC_BITS) + 25'd1;
		dy = 27'(cpy_q >> FRAC_BITS) + 27'd1;
		hit_x = ({2'b00, cx_q} < {2'b00, ow_eff}) &&
			((dx > 25'(wm1)) ? (wm1 == c_q) : (dx == 25'(c_q)));
		hit_y = (cy_q < oh_eff) &&
			((dy > 27'(hm1)) ? (hm1 == r_q) : (dy == 27'(r_q)));
		nonempty = (cx_q != x0_q) && (cy_q != nor_q);
		accept = in_valid && (state_q == S_IDLE);
	end

	bis_ram #(.WIDTH(24), .DEPTH(MAX_LINE_WIDTH)) u_line (
		.clk   (clk),
		.we    (state_q == S_READ),
		.waddr (c_q[CW-1:0]),
		.wdata (cur_q),
		.raddr (c_new[CW-1:0]),
		.rdata (rdata)
	);

	// Sequencer and frame position state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			in_width_q   <= 11'd640;
			in_height_q  <= 13'd480;
			out_width_q  <= 13'd640;
			out_height_q <= 15'd480;
			step_q       <= 11'd256;
			in_col_q     <= '0;
			in_row_q     <= '0;
			nor_q        <= '0;
			npy_q        <= '0;
			roc_q        <= '0;
			rpx_q        <= '0;
			left_q       <= '0;
			la_q         <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cur_q <= in_pixel;
						c_q   <= c_new;
						r_q   <= r_new;
						x0_q  <= (c_new == 13'd0) ? 13'd0 : roc_q;
						cx_q  <= (c_new == 13'd0) ? 13'd0 : roc_q;
						px0_q <= (c_new == 13'd0) ? 24'd0 : rpx_q;
						cpx_q <= (c_new == 13'd0) ? 24'd0 : rpx_q;
						cy_q  <= nor_q;
						cpy_q <= npy_q;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					above_q <= rdata;
					state_q <= S_SCANX;
				end
				S_SCANX: begin
					if (hit_x) begin
						cx_q  <= cx_q + 13'd1;
						cpx_q <= cpx_q + 24'(step_q);
					end else begin
						state_q <= S_SCANY;
					end
				end
				S_SCANY: begin
					if (hit_y) begin
						cy_q  <= cy_q + 15'd1;
						cpy_q <= cpy_q + 26'(step_q);
					end else begin
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (!(nonempty && qstat.full)) begin
						state_q <= S_IDLE;
						left_q  <= cur_q;
						la_q    <= above_q;
						if (c_q + 13'd1 >= w_eff) begin
							in_col_q <= '0;
							roc_q    <= '0;
							rpx_q    <= '0;
							if (r_q + 13'd1 >= h_eff) begin
								in_row_q <= '0;
								nor_q    <= '0;
								npy_q    <= '0;
							end else begin
								in_row_q <= 12'(r_q + 13'd1);
								nor_q    <= cy_q;
								npy_q    <= cpy_q;
							end
						end else begin
							in_col_q <= CW'(c_q + 13'd1);
							roc_q    <= cx_q;
							rpx_q    <= cpx_q;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// Any register write restarts the frame.
			if (cfg_we && cfg_index <= bis_pkg::REG_STEP) begin
				case (cfg_index)
					bis_pkg::REG_IN_WIDTH:   in_width_q   <= cfg_data[10:0];
					bis_pkg::REG_IN_HEIGHT:  in_height_q  <= cfg_data[12:0];
					bis_pkg::REG_OUT_WIDTH:  out_width_q  <= cfg_data[12:0];
					bis_pkg::REG_OUT_HEIGHT: out_height_q <= cfg_data[14:0];
					bis_pkg::REG_STEP:       step_q       <= cfg_data[10:0];
					default: ;
				endcase
				in_col_q <= '0;
				in_row_q <= '0;
				nor_q    <= '0;
				npy_q    <= '0;
				roc_q    <= '0;
				rpx_q    <= '0;
				left_q   <= '0;
				la_q     <= '0;
			end
		end
	end

	// Job handed to the back end.
	always_comb begin
		job.cur        = cur_q;
		job.above      = above_q;
		job.left       = left_q;
		job.left_above = la_q;
		job.col        = c_q;
		job.row        = r_q;
		job.x0         = x0_q;
		job.x1         = cx_q;
		job.px0        = px0_q;
		job.y0         = nor_q;
		job.y1         = cy_q;
		job.py0        = npy_q;
	end

	assign push     = (state_q == S_PUSH) && nonempty && !qstat.full;
	assign in_stall = (state_q != S_IDLE);
	assign step     = step_q;

endmodule

// File: design/bis_queue.sv
// Two-entry job queue between front and back end.
// Depends on bis_pkg.
module bis_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  bis_pkg::job_t          wjob,
	input  logic                   pop,
	output bis_pkg::job_t          head,
	output bis_pkg::queue_status_t qstat
);

	bis_pkg::job_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wjob;
		end
	end

	assign head        = mem_q[rp_q];
	assign qstat.full  = (cnt_q == 2'd2);
	assign qstat.empty = (cnt_q == 2'd0);

endmodule

// File: design/bis_back.sv
// Back end: walks the output block of a job and blends each output pixel.
// Depends on bis_pkg.
module bis_back #(
	parameter int FRAC_BITS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [10:0]            step,
	input  bis_pkg::job_t          head,
	input  bis_pkg::queue_status_t qstat,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [23:0]            out_pixel,
	output logic [11:0]            out_x,
	output logic [13:0]            out_y,
	output logic                   last
);

	localparam int WTW = 2 * FRAC_BITS + 1;
	localparam int SW = WTW + 10;
	localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

	bis_pkg::job_t job_q;
	logic        active_q;
	logic [12:0] ox_q;
	logic [14:0] oy_q;
	logic [23:0] px_q;
	logic [25:0] py_q;
	logic [5:0]  n_q;
	logic        en, fin, row_end, lf, up;

	logic                 v_s1, v_s2, v_s3;
	logic [23:0]          p00_s1, p01_s1, p10_s1, p11_s1;
	logic [23:0]          p00_s2, p01_s2, p10_s2, p11_s2;
	logic [FRAC_BITS-1:0] fx_s1, fy_s1;
	logic [WTW-1:0]       w00_s2, w01_s2, w10_s2, w11_s2;
	logic [12:0]          ox_s1, ox_s2;
	logic [14:0]          oy_s1, oy_s2;
	logic                 last_s1, last_s2;
	logic [23:0]          blend;

	// Pipeline advance and generator control.
	always_comb begin
		en      = !(v_s3 && out_stall);
		row_end = (ox_q + 13'd1 == job_q.x1);
		fin     = (n_q == bis_pkg::MAX_RESULTS_M1) || (row_end && (oy_q + 15'd1 == job_q.y1));
		lf      = (px_q >> FRAC_BITS) < 24'(job_q.col);
		up      = (py_q >> FRAC_BITS) < 26'(job_q.row);
		pop     = !active_q && !qstat.empty;
	end

	// Output pixel walk in raster order, at most one block of results per job.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (!active_q) begin
			if (!qstat.empty) begin
				job_q    <= head;
				ox_q     <= head.x0;
				px_q     <= head.px0;
				oy_q     <= head.y0;
				py_q     <= head.py0;
				n_q      <= '0;
				active_q <= 1'b1;
			end
		end else if (en) begin
			n_q <= n_q + 6'd1;
			if (fin) begin
				active_q <= 1'b0;
			end else if (row_end) begin
				ox_q <= job_q.x0;
				px_q <= job_q.px0;
				oy_q <= oy_q + 15'd1;
				py_q <= py_q + 26'(step);
			end else begin
				ox_q <= ox_q + 13'd1;
				px_q <= px_q + 24'(step);
			end
		end
	end

	// Valid bits of the blend pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= active_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Channel sums of the four weighted neighbors.
	always_comb begin
		logic [SW-1:0] s;
		blend = '0;
		for (int k = 0; k < 3; k++) begin
			s = SW'(w00_s2 * p00_s2[8*k +: 8]) + SW'(w01_s2 * p01_s2[8*k +: 8])
			  + SW'(w10_s2 * p10_s2[8*k +: 8]) + SW'(w11_s2 * p11_s2[8*k +: 8]);
			blend[8*k +: 8] = s[2*FRAC_BITS +: 8];
		end
	end

	// Neighbor select, weights, then blend.
	always_ff @(posedge clk) begin
		if (en) begin
			p00_s1  <= lf ? (up ? job_q.left_above : job_q.left) : (up ? job_q.above : job_q.cur);
			p01_s1  <= up ? job_q.above : job_q.cur;
			p10_s1  <= lf ? job_q.left : job_q.cur;
			p11_s1  <= job_q.cur;
			fx_s1   <= px_q[FRAC_BITS-1:0];
			fy_s1   <= py_q[FRAC_BITS-1:0];
			ox_s1   <= ox_q;
			oy_s1   <= oy_q;
			last_s1 <= fin;

			w00_s2  <= WTW'((ONE - {1'b0, fx_s1}) * (ONE - {1'b0, fy_s1}));
			w01_s2  <= WTW'({1'b0, fx_s1} * (ONE - {1'b0, fy_s1}));
			w10_s2  <= WTW'((ONE - {1'b0, fx_s1}) * {1'b0, fy_s1});
			w11_s2  <= WTW'({1'b0, fx_s1} * {1'b0, fy_s1});
			p00_s2  <= p00_s1;
			p01_s2  <= p01_s1;
			p10_s2  <= p10_s1;
			p11_s2  <= p11_s1;
			ox_s2   <= ox_s1;
			oy_s2   <= oy_s1;
			last_s2 <= last_s1;

			out_pixel <= blend;
			out_x     <= ox_s2[11:0];
			out_y     <= oy_s2[13:0];
			last      <= last_s2;
		end
	end

	assign out_valid = v_s3;

endmodule

// File: design/bilinear_image_scaler_top.sv
// Top level of the bilinear image scaler: front end, job queue, back end.
// Depends on bis_pkg, bis_front, bis_queue, bis_back and the defines header.
//
//   channel   direction  handshake              payload
//   input     in         in_valid / in_stall    in_pixel
//   output    out        out_valid / out_stall  out_pixel, out_x, out_y, last
//   config    in         cfg_we                 cfg_index, cfg_data
//
// The front end reads the line store for each word, scans the output columns
// and then the output rows that the word completes, and pushes the job; it takes
// no new word until it is idle again, and waits longer while the queue is full.
// The back end delivers one result per cycle within a job while the output is not
// stalled, through a 3-stage blend, with an idle load step before each new job.
// Reset clears all control state; the line store is not cleared.
// The queue lets the front end work ahead while the output stalls.
`include "bilinear_image_scaler_top_defines.svh"
module bilinear_image_scaler_top #(
	parameter int MAX_LINE_WIDTH = 1024,
	parameter int FRAC_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [14:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [23:0] in_pixel,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [23:0] out_pixel,
	output logic [11:0] out_x,
	output logic [13:0] out_y,
	output logic        last
);

	bis_pkg::job_t          fjob, head;
	bis_pkg::queue_status_t qstat;
	logic                   push, pop;
	logic [10:0]            step;

	bis_front #(.MAX_LINE_WIDTH(MAX_LINE_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_pixel  (in_pixel),
		.step      (step),
		.push      (push),
		.job       (fjob),
		.qstat     (qstat)
	);

	bis_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wjob   (fjob),
		.pop    (pop),
		.head   (head),
		.qstat  (qstat)
	);

	bis_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.head      (head),
		.qstat     (qstat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_pixel (out_pixel),
		.out_x     (out_x),
		.out_y     (out_y),
		.last      (last)
	);

	// The queue is never written when full nor read when empty.
	`BIS_ASSERT_NOW(a_no_overflow, push, !qstat.full)
	`BIS_ASSERT_NOW(a_no_underflow, pop, !qstat.empty)
	// A stalled result stays in place.
	`BIS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_pixel))

endmodule

// File: tb/bilinear_image_scaler_top_test.sv
// Self-checking testbench for the streaming bilinear image scaler.
// Depends on bis_pkg and bilinear_image_scaler_top; predicts every output word and compares.
`timescale 1ns / 100ps
module bilinear_image_scaler_top_test;

	localparam int LINE_MAX = 1024;
	localparam int FRAC = 8;
	localparam int RESULT_CAP = 64;
	localparam int SETTLE_CYCLES = 300;
	localparam int RANDOM_ITEMS = 200;

	typedef struct {
		logic [23:0] pixel;
		logic [11:0] x;
		logic [13:0] y;
		logic        last;
	} scaled_px_t;

	typedef struct {
		bit          is_cfg;
		logic [2:0]  idx;
		logic [23:0] data;
		bit          has_exp;
		logic [23:0] exp_px;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [14:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [23:0] in_pixel = '0;
	logic        out_valid;
	logic        out_stall = 1'b1;
	logic [23:0] out_pixel;
	logic [11:0] out_x;
	logic [13:0] out_y;
	logic        last;

	// Predictor state: scale settings and frame position.
	int unsigned sc_in_w, sc_in_h, sc_out_w, sc_out_h, sc_step;
	logic [23:0] row_above [LINE_MAX];
	logic [23:0] left_px, left_up_px;
	int unsigned col_pos, row_pos, out_row_next, out_col_next;

	scaled_px_t pending_px [$];
	int fail_cnt = 0;
	int words_in = 0;
	int words_out = 0;
	int cfg_phases = 0;
	bit burst_mode = 1'b0;
	bit long_hold = 1'b0;
	bit busy = 1'b0;

	bilinear_image_scaler_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_pixel(in_pixel),
		.out_valid(out_valid), .out_stall(out_stall), .out_pixel(out_pixel),
		.out_x(out_x), .out_y(out_y), .last(last)
	);

	always #6 clk = ~clk;

	// Hard limit on run time.
	initial begin
		#30000000;
		$display("Some tests failed");
		$finish;
	end

	function automatic longint unsigned src_whole(int unsigned o);
		return (longint'(o) * sc_step) >> FRAC;
	endfunction

	function automatic longint unsigned src_part(int unsigned o);
		return (longint'(o) * sc_step) & ((1 << FRAC) - 1);
	endfunction

	// Input index at which the source cell of output index o is complete.
	function automatic longint unsigned cell_done(int unsigned o, int unsigned lim);
		longint unsigned d;
		d = src_whole(o) + 1;
		return (d > lim - 1) ? lim - 1 : d;
	endfunction

	function automatic logic [23:0] mix4(logic [23:0] p00, logic [23:0] p01,
			logic [23:0] p10, logic [23:0] p11, longint unsigned fx, longint unsigned fy);
		longint unsigned one, w00, w01, w10, w11, acc;
		logic [23:0] res;
		one = 1 << FRAC;
		w00 = (one - fx) * (one - fy);
		w01 = fx * (one - fy);
		w10 = (one - fx) * fy;
		w11 = fx * fy;
		for (int sh = 0; sh < 24; sh += 8) begin
			acc = w00 * p00[sh +: 8] + w01 * p01[sh +: 8] + w10 * p10[sh +: 8]
				+ w11 * p11[sh +: 8];
			res[sh +: 8] = acc[2 * FRAC +: 8];
		end
		return res;
	endfunction

	task automatic restart_frame();
		left_px = '0;
		left_up_px = '0;
		col_pos = 0;
		row_pos = 0;
		out_row_next = 0;
		out_col_next = 0;
	endtask

	// Advance the predictor by one input word; queue its results when keep is set.
	task automatic predict_scale(logic [23:0] cur, bit keep);
		int unsigned w, h, ow, oh, c, r, cx0, cx1, ry1, n;
		logic [23:0] above, p00, p01, p10;
		bit up, lf;
		scaled_px_t res;
		w = (sc_in_w == 0) ? 1 : (sc_in_w > LINE_MAX ? LINE_MAX : sc_in_w);
		h = (sc_in_h == 0) ? 1 : (sc_in_h > 4096 ? 4096 : sc_in_h);
		ow = sc_out_w > 4096 ? 4096 : sc_out_w;
		oh = sc_out_h > 16384 ? 16384 : sc_out_h;
		c = col_pos >= w ? w - 1 : col_pos;
		r = row_pos >= h ? h - 1 : row_pos;
		n = 0;
		above = row_above[c];
		if (c == 0)
			out_col_next = 0;
		cx0 = out_col_next;
		cx1 = cx0;
		while (cx1 < ow && cell_done(cx1, w) == c)
			cx1++;
		ry1 = out_row_next;
		while (ry1 < oh && cell_done(ry1, h) == r)
			ry1++;
		for (int unsigned oy = out_row_next; oy < ry1; oy++) begin
			up = src_whole(oy) < r;
			for (int unsigned ox = cx0; ox < cx1; ox++) begin
				if (n < RESULT_CAP) begin
					lf = src_whole(ox) < c;
					p00 = lf ? (up ? left_up_px : left_px) : (up ? above : cur);
					p01 = up ? above : cur;
					p10 = lf ? left_px : cur;
					res.pixel = mix4(p00, p01, p10, cur, src_part(ox), src_part(oy));
					res.x = ox[11:0];
					res.y = oy[13:0];
					res.last = (n == RESULT_CAP - 1) ||
						(ox == cx1 - 1 && oy == ry1 - 1);
					if (keep)
						pending_px.push_back(res);
					n++;
				end
			end
		end
		out_col_next = cx1;
		row_above[c] = cur;
		left_up_px = above;
		left_px = cur;
		if (c + 1 >= w) begin
			col_pos = 0;
			out_row_next = ry1;
			out_col_next = 0;
			if (r + 1 >= h) begin
				row_pos = 0;
				out_row_next = 0;
			end else begin
				row_pos = r + 1;
			end
		end else begin
			col_pos = c + 1;
			row_pos = r;
		end
	endtask

	// Wait until every expected word is out and the front end has settled.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_px.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		busy = 1'b0;
	endtask

	task automatic write_reg(logic [2:0] idx, int unsigned val);
		if (busy)
			drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[14:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			bis_pkg::REG_IN_WIDTH:   sc_in_w = val & 'h7ff;
			bis_pkg::REG_IN_HEIGHT:  sc_in_h = val & 'h1fff;
			bis_pkg::REG_OUT_WIDTH:  sc_out_w = val & 'h1fff;
			bis_pkg::REG_OUT_HEIGHT: sc_out_h = val & 'h7fff;
			bis_pkg::REG_STEP:       sc_step = val & 'h7ff;
			default: ;
		endcase
		restart_frame();
	endtask

	task automatic set_scale(int unsigned iw, int unsigned ih, int unsigned ow,
			int unsigned oh, int unsigned st);
		write_reg(bis_pkg::REG_IN_WIDTH, iw);
		write_reg(bis_pkg::REG_IN_HEIGHT, ih);
		write_reg(bis_pkg::REG_OUT_WIDTH, ow);
		write_reg(bis_pkg::REG_OUT_HEIGHT, oh);
		write_reg(bis_pkg::REG_STEP, st);
		cfg_phases++;
	endtask

	// Offer one word after a random gap and hold it until it is taken.
	task automatic send_pixel(logic [23:0] px, bit typed, logic [23:0] typed_px);
		int gap;
		scaled_px_t res;
		gap = burst_mode ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_pixel <= px;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		busy = 1'b1;
		words_in++;
		if (typed) begin
			res.pixel = typed_px;
			res.x = '0;
			res.y = '0;
			res.last = 1'b1;
			pending_px.push_back(res);
		end
		predict_scale(px, !typed);
	endtask

	// Output side: random stall per word, plus one long hold on request.
	initial begin
		int k;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (600) @(posedge clk);
				long_hold = 1'b0;
			end
			k = burst_mode ? 0 : $urandom_range(0, 16);
			if (k != 0) begin
				out_stall <= 1'b1;
				repeat (k) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Compare each delivered word with the oldest expectation.
	always @(posedge clk) begin
		scaled_px_t e;
		if (arst_n && out_valid && !out_stall) begin
			words_out++;
			if (pending_px.size() == 0) begin
				$error("unexpected output word x=%0d y=%0d pixel=%h", out_x, out_y, out_pixel);
				fail_cnt++;
			end else begin
				e = pending_px.pop_front();
				if (out_pixel !== e.pixel) begin
					$error("out_pixel expected %h actual %h", e.pixel, out_pixel);
					fail_cnt++;
				end
				if (out_x !== e.x) begin
					$error("out_x expected %0d actual %0d", e.x, out_x);
					fail_cnt++;
				end
				if (out_y !== e.y) begin
					$error("out_y expected %0d actual %0d", e.y, out_y);
					fail_cnt++;
				end
				if (last !== e.last) begin
					$error("last expected %0d actual %0d", e.last, last);
					fail_cnt++;
				end
			end
		end
	end

	initial begin
		stim_row_t dir_tab [$];
		int unsigned iw, ih, ow, oh, st, frames, cnt;
		sc_in_w = 640;
		sc_in_h = 480;
		sc_out_w = 640;
		sc_out_h = 480;
		sc_step = 256;
		for (int i = 0; i < LINE_MAX; i++)
			row_above[i] = '0;
		restart_frame();

		// Directed words: 1x1 frames pass pixels through, then small special cases.
		dir_tab = '{
			'{1, bis_pkg::REG_IN_WIDTH, 1, 0, 0}, '{1, bis_pkg::REG_IN_HEIGHT, 1, 0, 0},
			'{1, bis_pkg::REG_OUT_WIDTH, 1, 0, 0}, '{1, bis_pkg::REG_OUT_HEIGHT, 1, 0, 0},
			'{1, bis_pkg::REG_STEP, 256, 0, 0},
			'{0, 0, 24'hffffff, 1, 24'hffffff}, '{0, 0, 24'h000000, 1, 24'h000000},
			'{0, 0, 24'ha5c3f0, 1, 24'ha5c3f0},
			// Upscale by two from a 2x2 frame.
			'{1, bis_pkg::REG_IN_WIDTH, 2, 0, 0}, '{1, bis_pkg::REG_IN_HEIGHT, 2, 0, 0},
			'{1, bis_pkg::REG_OUT_WIDTH, 4, 0, 0}, '{1, bis_pkg::REG_OUT_HEIGHT, 4, 0, 0},
			'{1, bis_pkg::REG_STEP, 128, 0, 0},
			'{0, 0, 24'hff0000, 0, 0}, '{0, 0, 24'h00ff00, 0, 0},
			'{0, 0, 24'h0000ff, 0, 0}, '{0, 0, 24'hffffff, 0, 0},
			// More than 64 outputs completed by one word; the rest are dropped.
			'{1, bis_pkg::REG_OUT_WIDTH, 9, 0, 0}, '{1, bis_pkg::REG_OUT_HEIGHT, 9, 0, 0},
			'{1, bis_pkg::REG_STEP, 64, 0, 0},
			'{0, 0, 24'h123456, 0, 0}, '{0, 0, 24'h89abcd, 0, 0},
			'{0, 0, 24'hfedcba, 0, 0}, '{0, 0, 24'h0f0f0f, 0, 0},
			// Zero step samples the origin only.
			'{1, bis_pkg::REG_STEP, 0, 0, 0}, '{1, bis_pkg::REG_OUT_WIDTH, 3, 0, 0},
			'{0, 0, 24'h5a5a5a, 0, 0}, '{0, 0, 24'hc0ffee, 0, 0},
			// Zero input width counts as one; zero output width gives nothing.
			'{1, bis_pkg::REG_IN_WIDTH, 0, 0, 0}, '{1, bis_pkg::REG_STEP, 256, 0, 0},
			'{0, 0, 24'h777777, 0, 0}, '{0, 0, 24'h010203, 0, 0},
			'{1, bis_pkg::REG_OUT_WIDTH, 0, 0, 0},
			'{0, 0, 24'h999999, 0, 0}, '{0, 0, 24'h333333, 0, 0}
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg)
				write_reg(dir_tab[i].idx, dir_tab[i].data);
			else
				send_pixel(dir_tab[i].data, dir_tab[i].has_exp, dir_tab[i].exp_px);
		end
		cfg_phases++;

		// Largest register values: clamped sizes, steepest downscale, one row only.
		set_scale(2047, 8191, 8191, 32767, 2047);
		for (int i = 0; i < 30; i++)
			send_pixel($urandom_range(0, 24'hffffff), 0, 0);

		// Random frames; the output is held off for a while at the start.
		long_hold = 1'b1;
		cnt = 0;
		while (cnt < RANDOM_ITEMS) begin
			iw = $urandom_range(1, 6);
			ih = $urandom_range(1, 5);
			st = $urandom_range(64, 1024);
			ow = (iw * 256 + st / 2) / st;
			oh = (ih * 256 + st / 2) / st;
			if (ow == 0) ow = 1;
			if (oh == 0) oh = 1;
			if ($urandom_range(0, 5) == 0) begin
				ow = $urandom_range(0, 12);
				oh = $urandom_range(0, 12);
			end
			set_scale(iw, ih, ow, oh, st);
			burst_mode = ($urandom_range(0, 3) == 0);
			frames = $urandom_range(1, 2);
			// Now and then cut the frame short before reconfiguring.
			if ($urandom_range(0, 7) == 0)
				frames = 0;
			for (int i = 0; i < (frames == 0 ? $urandom_range(1, iw * ih) : iw * ih * frames);
					i++) begin
				send_pixel($urandom_range(0, 24'hffffff), 0, 0);
				cnt++;
			end
		end
		burst_mode = 1'b0;
		drain();

		$display("Covered %0d input words and %0d output words over %0d scale settings.",
			words_in, words_out, cfg_phases);
		if (fail_cnt == 0 && pending_px.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
